FILE: src/cotd_pkg.sv
// ----------------------------------------------------------------------------
// CFF operand token decoder package
// Token kinds, lead byte codes and the record passed from parser to output.
// ----------------------------------------------------------------------------
`default_nettype none

package cotd_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        TK_INTEGER  = 2'd0,
        TK_OPERATOR = 2'd1,
        TK_REAL_NIB = 2'd2,
        TK_TRUNC    = 2'd3
    } t_token_kind;

    localparam logic [7:0] BYTE_ESCAPE    = 8'd12;
    localparam logic [7:0] BYTE_ENDCHAR   = 8'd14;
    localparam logic [7:0] BYTE_SHORTINT  = 8'd28;
    localparam logic [7:0] BYTE_LONGINT   = 8'd29;
    localparam logic [7:0] BYTE_REAL      = 8'd30;
    localparam logic [7:0] BYTE_SMALL_LO  = 8'd32;
    localparam logic [7:0] BYTE_SMALL_HI  = 8'd246;
    localparam logic [7:0] BYTE_POS_LO    = 8'd247;
    localparam logic [7:0] BYTE_POS_HI    = 8'd250;
    localparam logic [7:0] BYTE_NEG_HI    = 8'd254;
    localparam logic [7:0] ESCAPE_PREFIX  = 8'h0C;
    localparam logic [3:0] NIB_END        = 4'hF;
    localparam logic [3:0] NIB_SKIP       = 4'hD;
    localparam logic [31:0] SMALL_BIAS    = 32'd139;
    localparam logic [31:0] TWO_BYTE_BIAS = 32'd108;

    // One or two tokens caused by one input byte; a second token is always
    // a real nibble with the same count as the first.
    typedef struct packed {
        t_token_kind        kind;
        logic signed [31:0] value;
        logic [7:0]         count;
        logic               two;
        logic [3:0]         nib2;
        logic               done;
    } t_bundle;

endpackage

`default_nettype wire

FILE: src/cotd_byte_if.sv
// ----------------------------------------------------------------------------
// CFF byte channel
// Valid/ready channel carrying one data byte and its end-of-string mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface cotd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

FILE: src/cotd_token_if.sv
// ----------------------------------------------------------------------------
// CFF token channel
// Valid/ready channel carrying one decoded token.
// ----------------------------------------------------------------------------
`default_nettype none

interface cotd_token_if;
    logic               valid;
    logic               ready;
    logic [1:0]         token_kind;
    logic signed [31:0] token_value;
    logic [7:0]         operand_count;
    logic               last_of_run;
    logic               string_done;

    modport source (output valid, output token_kind, output token_value,
                    output operand_count, output last_of_run, output string_done,
                    input ready);
    modport sink   (input valid, input token_kind, input token_value,
                    input operand_count, input last_of_run, input string_done,
                    output ready);
endinterface

`default_nettype wire

FILE: src/cotd_front.sv
// ----------------------------------------------------------------------------
// CFF token parser
// Accepts one byte per transfer, tracks the parse phase and pushes the
// tokens that the byte causes into the queue as one record.
// ----------------------------------------------------------------------------
`default_nettype none

module cotd_front
    import cotd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_cfg_wr_en,
    input  wire logic    i_cfg_wr_data,
    cotd_byte_if.sink    i_byte,
    input  wire logic    i_full,
    output logic         o_push,
    output t_bundle      o_bundle
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_OPERAND,
        PH_ESCAPE,
        PH_REAL
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_bytes_left, n_bytes_left;
    logic [31:0] r_acc, n_acc;
    logic [7:0]  r_lead, n_lead;
    logic [7:0]  r_pending, n_pending;
    logic        r_stopped, n_stopped;
    logic        r_mode;

    logic        accept;
    logic        have;
    t_bundle     bund;
    logic [7:0]  b;
    logic        eos;
    logic [31:0] acc_shift;
    logic [2:0]  left_dec;
    logic [3:0]  hi, lo;
    logic [31:0] mag;
    logic [31:0] decoded;
    logic [7:0]  pending_inc;

    assign accept       = i_byte.valid && !i_full;
    assign i_byte.ready = !i_full;
    assign b            = i_byte.in_byte;
    assign eos          = i_byte.end_of_string;
    assign acc_shift    = {r_acc[23:0], b};
    assign left_dec     = r_bytes_left - 3'd1;
    assign hi           = b[7:4];
    assign lo           = b[3:0];
    assign pending_inc  = (r_pending == 8'hFF) ? r_pending : r_pending + 8'd1;
    assign mag          = {22'd0, r_lead[1:0] + 2'd1, acc_shift[7:0]} + TWO_BYTE_BIAS;

    always_comb begin
        priority if (r_lead == BYTE_SHORTINT) begin
            decoded = {{16{acc_shift[15]}}, acc_shift[15:0]};
        end else if (r_lead == BYTE_LONGINT) begin
            decoded = acc_shift;
        end else if (r_lead <= BYTE_POS_HI) begin
            decoded = mag;
        end else begin
            decoded = 32'd0 - mag;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_acc        = r_acc;
        n_lead       = r_lead;
        n_pending    = r_pending;
        n_stopped    = r_stopped;
        have         = 1'b0;
        bund.kind    = TK_INTEGER;
        bund.value   = 32'sd0;
        bund.count   = r_pending;
        bund.two     = 1'b0;
        bund.nib2    = 4'd0;
        bund.done    = eos;

        if (!r_stopped) begin
            unique case (r_phase)
                PH_IDLE: begin
                    priority if (b >= BYTE_SMALL_LO && b <= BYTE_SMALL_HI) begin
                        have       = 1'b1;
                        bund.kind  = TK_INTEGER;
                        bund.value = {24'd0, b} - SMALL_BIAS;
                        n_pending  = pending_inc;
                    end else if (b >= BYTE_POS_LO && b <= BYTE_NEG_HI) begin
                        n_lead       = b;
                        n_acc        = 32'd0;
                        n_bytes_left = 3'd1;
                        n_phase      = PH_OPERAND;
                    end else if (b == BYTE_SHORTINT) begin
                        n_lead       = b;
                        n_acc        = 32'd0;
                        n_bytes_left = 3'd2;
                        n_phase      = PH_OPERAND;
                    end else if (b == BYTE_LONGINT) begin
                        n_lead       = b;
                        n_acc        = 32'd0;
                        n_bytes_left = 3'd4;
                        n_phase      = PH_OPERAND;
                    end else if (b == BYTE_REAL && !r_mode) begin
                        n_phase = PH_REAL;
                    end else if (b == BYTE_ESCAPE && !eos) begin
                        n_phase = PH_ESCAPE;
                    end else begin
                        have       = 1'b1;
                        bund.kind  = TK_OPERATOR;
                        bund.value = {24'd0, b};
                        n_pending  = 8'd0;
                        if (r_mode && b == BYTE_ENDCHAR) begin
                            n_stopped = 1'b1;
                            bund.done = 1'b1;
                        end
                    end
                    if (n_phase == PH_OPERAND && eos) begin
                        have       = 1'b1;
                        bund.kind  = TK_TRUNC;
                        bund.value = {24'd0, b};
                    end
                end
                PH_OPERAND: begin
                    n_acc        = acc_shift;
                    n_bytes_left = left_dec;
                    if (left_dec == 3'd0) begin
                        have       = 1'b1;
                        bund.kind  = TK_INTEGER;
                        bund.value = decoded;
                        n_pending  = pending_inc;
                        n_phase    = PH_IDLE;
                    end else if (eos) begin
                        have       = 1'b1;
                        bund.kind  = TK_TRUNC;
                        bund.value = {24'd0, r_lead};
                    end
                end
                PH_ESCAPE: begin
                    have       = 1'b1;
                    bund.kind  = TK_OPERATOR;
                    bund.value = {16'd0, ESCAPE_PREFIX, b};
                    n_pending  = 8'd0;
                    n_phase    = PH_IDLE;
                end
                PH_REAL: begin
                    bund.kind = TK_REAL_NIB;
                    if (hi != NIB_SKIP) begin
                        have       = 1'b1;
                        bund.value = {28'd0, hi};
                    end
                    if (hi == NIB_END) begin
                        n_pending = pending_inc;
                        n_phase   = PH_IDLE;
                    end else begin
                        if (lo != NIB_SKIP) begin
                            if (have) begin
                                bund.two  = 1'b1;
                                bund.nib2 = lo;
                            end else begin
                                have       = 1'b1;
                                bund.value = {28'd0, lo};
                            end
                        end
                        if (lo == NIB_END) begin
                            n_pending = pending_inc;
                            n_phase   = PH_IDLE;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        if (eos) begin
            n_phase      = PH_IDLE;
            n_bytes_left = 3'd0;
            n_pending    = 8'd0;
            n_stopped    = 1'b0;
        end
    end

    assign o_push   = accept && have;
    assign o_bundle = bund;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bytes_left <= 3'd0;
            r_acc        <= 32'd0;
            r_lead       <= 8'd0;
            r_pending    <= 8'd0;
            r_stopped    <= 1'b0;
            r_mode       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (accept) begin
                r_phase      <= n_phase;
                r_bytes_left <= n_bytes_left;
                r_acc        <= n_acc;
                r_lead       <= n_lead;
                r_pending    <= n_pending;
                r_stopped    <= n_stopped;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_operand_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_OPERAND) |-> (r_bytes_left != 3'd0))
        else $error("operand phase with no bytes left");
    a_stop_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_phase == PH_IDLE))
        else $error("parser stopped outside idle phase");
`endif

endmodule

`default_nettype wire

FILE: src/cotd_queue.sv
// ----------------------------------------------------------------------------
// CFF token queue
// Short register queue of token records between parser and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cotd_queue
    import cotd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_bundle   i_data,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_bundle   o_head
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

FILE: src/cotd_back.sv
// ----------------------------------------------------------------------------
// CFF token output stage
// Splits each queued record into single tokens and holds them in the
// output register until transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module cotd_back
    import cotd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_empty,
    input  t_bundle      i_head,
    output logic         o_pop,
    cotd_token_if.source o_token
);

    logic               r_valid;
    logic               r_second;
    logic [1:0]         r_kind;
    logic signed [31:0] r_value;
    logic [7:0]         r_count;
    logic               r_last;
    logic               r_done;

    logic load;
    logic take;
    logic split_first;

    assign load        = !r_valid || o_token.ready;
    assign take        = load && !i_empty;
    assign split_first = i_head.two && !r_second;
    assign o_pop       = take && !split_first;

    assign o_token.valid         = r_valid;
    assign o_token.token_kind    = r_kind;
    assign o_token.token_value   = r_value;
    assign o_token.operand_count = r_count;
    assign o_token.last_of_run   = r_last;
    assign o_token.string_done   = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
            r_kind   <= 2'd0;
            r_value  <= 32'sd0;
            r_count  <= 8'd0;
            r_last   <= 1'b0;
            r_done   <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (take) begin
                r_count <= i_head.count;
                r_done  <= i_head.done;
                if (r_second) begin
                    r_kind  <= TK_REAL_NIB;
                    r_value <= {28'd0, i_head.nib2};
                end else begin
                    r_kind  <= i_head.kind;
                    r_value <= i_head.value;
                end
                r_last   <= !split_first;
                r_second <= split_first;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_second_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (!i_empty && i_head.two))
        else $error("second nibble pending without its record");
`endif

endmodule

`default_nettype wire

FILE: src/cff_operand_token_decoder.sv
// ----------------------------------------------------------------------------
// CFF operand token decoder
// Decodes CFF DICT and Type 2 charstring bytes into operand, operator,
// real nibble and truncation tokens.
// ----------------------------------------------------------------------------
// Datapath: each accepted byte's record is written into the token queue, and
//   its tokens are then registered in the output register until transferred.
// Throughput: one byte per cycle while the queue is not full; output is one token
//   per cycle when ready, so a real byte with two nibbles gives two tokens.
// The token queue (QUEUE_DEPTH records) absorbs output stalls.
// Reset: synchronous, active low; parser idle, count cleared, DICT mode.
// ----------------------------------------------------------------------------
`default_nettype none

module cff_operand_token_decoder
    import cotd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_cfg_wr_en,
    input  wire logic    i_cfg_wr_data,
    cotd_byte_if.sink    i_byte,
    cotd_token_if.source o_token
);

    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    t_bundle push_data;
    t_bundle head;

    cotd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte        (i_byte),
        .i_full        (full),
        .o_push        (push),
        .o_bundle      (push_data)
    );

    cotd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    cotd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_token (o_token)
    );

endmodule

`default_nettype wire
